@@ rtl/ttlb_pkg.sv @@
package ttlb_pkg;

  typedef logic [2:0]  kind_t;
  typedef logic [1:0]  mode_t;
  typedef logic [31:0] ms_t;
  typedef logic [15:0] five_s_t;
  typedef logic [3:0]  led_t;

  localparam kind_t KIND_TICK      = 3'd0;
  localparam kind_t KIND_ARM_WATCH = 3'd1;
  localparam kind_t KIND_SET_MODE  = 3'd2;
  localparam kind_t KIND_SEND_GO   = 3'd3;
  localparam kind_t KIND_SEND_DONE = 3'd4;

  localparam mode_t MODE_BLINK = 2'd0;
  localparam mode_t MODE_CLEAR = 2'd1;
  localparam mode_t MODE_IDLE  = 2'd2;
  localparam mode_t MODE_FLASH = 2'd3;

  localparam ms_t          MS_WRAP      = 32'hFFFF_FFFF;
  localparam logic [12:0]  SLICE_LIMIT  = 13'd5000;
  localparam logic [17:0]  SEND_LIMIT   = 18'd120000;
  localparam logic [13:0]  WATCH_LIMIT  = 14'd10000;

  typedef struct packed {
    ms_t     millisecond_count;
    five_s_t five_second_count;
    led_t    led_drive;
    logic    send_ok;
    logic    watchdog_armed;
    logic    watchdog_expired;
    logic    send_timed_out;
    mode_t   led_mode_now;
  } res_t;

endpackage

@@ rtl/ttlb_in_if.sv @@
interface ttlb_in_if import ttlb_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t kind;
  mode_t mode_value;
  logic  link_halted;

  modport source (output valid, output kind, output mode_value, output link_halted,
                  input ready);
  modport sink (input valid, input kind, input mode_value, input link_halted,
                output ready);
endinterface

@@ rtl/ttlb_out_if.sv @@
interface ttlb_out_if import ttlb_pkg::*; ();
  logic    valid;
  logic    ready;
  ms_t     millisecond_count;
  five_s_t five_second_count;
  led_t    led_drive;
  logic    send_ok;
  logic    watchdog_armed;
  logic    watchdog_expired;
  logic    send_timed_out;
  mode_t   led_mode_now;

  modport source (output valid, output millisecond_count, output five_second_count,
                  output led_drive, output send_ok, output watchdog_armed,
                  output watchdog_expired, output send_timed_out, output led_mode_now,
                  input ready);
  modport sink (input valid, input millisecond_count, input five_second_count,
                input led_drive, input send_ok, input watchdog_armed,
                input watchdog_expired, input send_timed_out, input led_mode_now,
                output ready);
endinterface

@@ rtl/tick_timers_with_led_blinker.sv @@
// the result of a transfer is valid on out_ch in the cycle after it is taken
// throughput: one item per cycle while out_ch is ready; the timer state
// updates in one register pass; no item is taken while a result waits unread
// reset: synchronous, active low; clears all timers, flags, mode and leds,
// the four-led select and the output valid
module tick_timers_with_led_blinker import ttlb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  ttlb_in_if.sink    in_ch,
  ttlb_out_if.source out_ch
);

  localparam logic [9:0] PH_1    = 10'd1;
  localparam logic [9:0] PH_51   = 10'd51;
  localparam logic [9:0] PH_101  = 10'd101;
  localparam logic [9:0] PH_201  = 10'd201;
  localparam logic [9:0] PH_250  = 10'd250;
  localparam logic [9:0] PH_500  = 10'd500;
  localparam logic [9:0] PH_750  = 10'd750;
  localparam logic [9:0] PH_1000 = 10'd1000;

  logic        four_led_r;
  logic        half_tick_r,   half_tick_nxt;
  ms_t         ms_r,          ms_nxt;
  logic [12:0] slice_r,       slice_nxt;
  five_s_t     five_s_r,      five_s_nxt;
  logic [16:0] send_timer_r,  send_timer_nxt;
  logic        send_ok_r,     send_ok_nxt;
  logic [13:0] watch_timer_r, watch_timer_nxt;
  logic        watch_armed_r, watch_armed_nxt;
  logic [9:0]  phase_r,       phase_nxt;
  mode_t       mode_r,        mode_nxt;
  led_t        led_r,         led_nxt;
  logic        expired_nxt,   timed_out_nxt;

  res_t        res_r;
  logic        out_valid_r;
  logic        in_xfer;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [17:0] send_sum;
    logic [9:0]  ph;

    half_tick_nxt   = half_tick_r;
    ms_nxt          = ms_r;
    slice_nxt       = slice_r;
    five_s_nxt      = five_s_r;
    send_timer_nxt  = send_timer_r;
    send_ok_nxt     = send_ok_r;
    watch_timer_nxt = watch_timer_r;
    watch_armed_nxt = watch_armed_r;
    phase_nxt       = phase_r;
    mode_nxt        = mode_r;
    led_nxt         = led_r;
    expired_nxt     = 1'b0;
    timed_out_nxt   = 1'b0;
    send_sum        = {1'b0, send_timer_r} + 18'd1;
    ph              = phase_r + 10'd1;

    unique case (in_ch.kind)
      KIND_TICK: begin
        half_tick_nxt = !half_tick_r;
        if (half_tick_r) begin
          // one millisecond
          ms_nxt = ms_r + 32'd1;
          if (ms_nxt == MS_WRAP) begin
            ms_nxt = '0;
          end

          slice_nxt = slice_r + 13'd1;
          if (slice_nxt >= SLICE_LIMIT) begin
            slice_nxt  = '0;
            five_s_nxt = five_s_r + 16'd1;
          end

          if (!in_ch.link_halted) begin
            if (!send_ok_r) begin
              if (send_sum >= SEND_LIMIT) begin
                send_timer_nxt = '0;
                send_ok_nxt    = 1'b1;
                timed_out_nxt  = 1'b1;
              end else begin
                send_timer_nxt = send_sum[16:0];
              end
            end else begin
              send_timer_nxt = '0;
            end
          end

          if (watch_armed_r) begin
            watch_timer_nxt = watch_timer_r + 14'd1;
            if (watch_timer_nxt >= WATCH_LIMIT) begin
              watch_timer_nxt = '0;
              watch_armed_nxt = 1'b0;
              expired_nxt     = 1'b1;
            end
          end

          unique case (mode_r)
            MODE_BLINK: begin
              phase_nxt = ph;
              if (four_led_r) begin
                if (ph == PH_250) led_nxt = 4'b0001;
                if (ph == PH_500) led_nxt = 4'b0010;
                if (ph == PH_750) led_nxt = 4'b0100;
                if (ph == PH_1000) begin
                  phase_nxt = '0;
                  led_nxt   = 4'b1000;
                end
              end else begin
                if (ph == PH_500) led_nxt = {led_r[3:2], 2'b01};
                if (ph == PH_1000) begin
                  phase_nxt = '0;
                  led_nxt   = {led_r[3:2], 2'b10};
                end
              end
            end
            MODE_CLEAR: begin
              led_nxt   = four_led_r ? 4'b0000 : {led_r[3:2], 2'b00};
              phase_nxt = '0;
              mode_nxt  = MODE_IDLE;
            end
            MODE_IDLE: begin
              led_nxt   = four_led_r ? {1'b0, led_r[2:0]} : {led_r[3:2], 1'b0, led_r[0]};
              phase_nxt = '0;
            end
            default: begin
              phase_nxt = ph;
              if (four_led_r) begin
                if (ph == PH_1)   led_nxt[3] = 1'b1;
                if (ph == PH_101) led_nxt[3] = 1'b0;
                if (ph == PH_201) phase_nxt  = '0;
              end else begin
                if (ph == PH_1)   led_nxt[1] = 1'b1;
                if (ph == PH_51)  led_nxt[1] = 1'b0;
                if (ph >= PH_101) phase_nxt  = '0;
              end
            end
          endcase
        end
      end
      KIND_ARM_WATCH: watch_armed_nxt = 1'b1;
      KIND_SET_MODE:  mode_nxt        = in_ch.mode_value;
      KIND_SEND_GO:   send_ok_nxt     = 1'b0;
      KIND_SEND_DONE: send_ok_nxt     = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_led_r    <= 1'b0;
      half_tick_r   <= 1'b0;
      ms_r          <= '0;
      slice_r       <= '0;
      five_s_r      <= '0;
      send_timer_r  <= '0;
      send_ok_r     <= 1'b0;
      watch_timer_r <= '0;
      watch_armed_r <= 1'b0;
      phase_r       <= '0;
      mode_r        <= MODE_BLINK;
      led_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        four_led_r <= cfg_wdata;
      end
      if (in_xfer) begin
        half_tick_r   <= half_tick_nxt;
        ms_r          <= ms_nxt;
        slice_r       <= slice_nxt;
        five_s_r      <= five_s_nxt;
        send_timer_r  <= send_timer_nxt;
        send_ok_r     <= send_ok_nxt;
        watch_timer_r <= watch_timer_nxt;
        watch_armed_r <= watch_armed_nxt;
        phase_r       <= phase_nxt;
        mode_r        <= mode_nxt;
        led_r         <= led_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r.millisecond_count <= ms_nxt;
      res_r.five_second_count <= five_s_nxt;
      res_r.led_drive         <= led_nxt;
      res_r.send_ok           <= send_ok_nxt;
      res_r.watchdog_armed    <= watch_armed_nxt;
      res_r.watchdog_expired  <= expired_nxt;
      res_r.send_timed_out    <= timed_out_nxt;
      res_r.led_mode_now      <= mode_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.millisecond_count = res_r.millisecond_count;
  assign out_ch.five_second_count = res_r.five_second_count;
  assign out_ch.led_drive         = res_r.led_drive;
  assign out_ch.send_ok           = res_r.send_ok;
  assign out_ch.watchdog_armed    = res_r.watchdog_armed;
  assign out_ch.watchdog_expired  = res_r.watchdog_expired;
  assign out_ch.send_timed_out    = res_r.send_timed_out;
  assign out_ch.led_mode_now      = res_r.led_mode_now;

endmodule

@@ dv/testbench.sv @@
module testbench;
  import ttlb_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int MAX_PRINTS  = 50;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic cfg_wdata;

  ttlb_in_if  in_ch ();
  ttlb_out_if out_ch ();

  tick_timers_with_led_blinker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timer and led state as the block should hold it
  logic        four_led     = 1'b0;
  logic        half_ms      = 1'b0;
  ms_t         ms_count     = '0;
  logic [12:0] slice_count  = '0;
  five_s_t     five_s_count = '0;
  logic [16:0] send_wait    = '0;
  logic        send_ok_now  = 1'b0;
  logic [13:0] wd_count     = '0;
  logic        wd_running   = 1'b0;
  logic [9:0]  led_phase    = '0;
  mode_t       led_mode     = MODE_BLINK;
  led_t        led_state    = '0;

  res_t pending_results[$];
  int   mismatches = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;
  bit   hold_req = 1'b0;
  bit   hold_ack = 1'b0;

  function automatic void step_led_pattern();
    case (led_mode)
      MODE_BLINK: begin
        led_phase = led_phase + 10'd1;
        if (four_led) begin
          if (led_phase == 10'd250) led_state = 4'b0001;
          if (led_phase == 10'd500) led_state = 4'b0010;
          if (led_phase == 10'd750) led_state = 4'b0100;
          if (led_phase == 10'd1000) begin
            led_phase = '0;
            led_state = 4'b1000;
          end
        end else begin
          if (led_phase == 10'd500) led_state = {led_state[3:2], 2'b01};
          if (led_phase == 10'd1000) begin
            led_phase = '0;
            led_state = {led_state[3:2], 2'b10};
          end
        end
      end
      MODE_CLEAR: begin
        led_state = four_led ? 4'b0000 : {led_state[3:2], 2'b00};
        led_phase = '0;
        led_mode  = MODE_IDLE;
      end
      MODE_IDLE: begin
        led_state = led_state & (four_led ? 4'b0111 : 4'b1101);
        led_phase = '0;
      end
      default: begin
        led_phase = led_phase + 10'd1;
        if (four_led) begin
          if (led_phase == 10'd1) led_state[3] = 1'b1;
          if (led_phase == 10'd101) led_state[3] = 1'b0;
          if (led_phase == 10'd201) led_phase = '0;
        end else begin
          if (led_phase == 10'd1) led_state[1] = 1'b1;
          if (led_phase == 10'd51) led_state[1] = 1'b0;
          if (led_phase >= 10'd101) led_phase = '0;
        end
      end
    endcase
  endfunction

  function automatic res_t advance_timers(kind_t kind, mode_t mode, logic halted);
    res_t r;
    logic expired;
    logic timed_out;
    expired   = 1'b0;
    timed_out = 1'b0;
    case (kind)
      KIND_TICK: begin
        half_ms = ~half_ms;
        if (!half_ms) begin
          ms_count = ms_count + 32'd1;
          if (ms_count == MS_WRAP) ms_count = '0;
          slice_count = slice_count + 13'd1;
          if (slice_count >= SLICE_LIMIT) begin
            slice_count  = '0;
            five_s_count = five_s_count + 16'd1;
          end
          if (!halted) begin
            if (!send_ok_now) begin
              send_wait = send_wait + 17'd1;
              if (send_wait >= SEND_LIMIT) begin
                send_wait   = '0;
                send_ok_now = 1'b1;
                timed_out   = 1'b1;
              end
            end else begin
              send_wait = '0;
            end
          end
          if (wd_running) begin
            wd_count = wd_count + 14'd1;
            if (wd_count >= WATCH_LIMIT) begin
              wd_count   = '0;
              wd_running = 1'b0;
              expired    = 1'b1;
            end
          end
          step_led_pattern();
        end
      end
      KIND_ARM_WATCH: wd_running = 1'b1;
      KIND_SET_MODE:  led_mode = mode;
      KIND_SEND_GO:   send_ok_now = 1'b0;
      KIND_SEND_DONE: send_ok_now = 1'b1;
      default: ;
    endcase
    r.millisecond_count = ms_count;
    r.five_second_count = five_s_count;
    r.led_drive         = led_state;
    r.send_ok           = send_ok_now;
    r.watchdog_armed    = wd_running;
    r.watchdog_expired  = expired;
    r.send_timed_out    = timed_out;
    r.led_mode_now      = led_mode;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_PRINTS)
          $display("%0t unexpected result: expected none, actual ms %0h", $time,
                   out_ch.millisecond_count);
      end else begin
        want = pending_results.pop_front();
        check_field("millisecond_count", want.millisecond_count, out_ch.millisecond_count);
        check_field("five_second_count", want.five_second_count, out_ch.five_second_count);
        check_field("led_drive", want.led_drive, out_ch.led_drive);
        check_field("send_ok", want.send_ok, out_ch.send_ok);
        check_field("watchdog_armed", want.watchdog_armed, out_ch.watchdog_armed);
        check_field("watchdog_expired", want.watchdog_expired, out_ch.watchdog_expired);
        check_field("send_timed_out", want.send_timed_out, out_ch.send_timed_out);
        check_field("led_mode_now", want.led_mode_now, out_ch.led_mode_now);
      end
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  initial begin
    int pat;
    int pat_left;
    int hold_left;
    pat       = 0;
    pat_left  = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (pat_left == 0) begin
        pat      = $urandom_range(0, 3);
        pat_left = $urandom_range(20, 300);
      end
      pat_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (pat)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= (pat_left % 3 != 0);
          default: out_ch.ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                               : $urandom_range(0, 40);
    end
  endtask

  task automatic send_item(kind_t kind, mode_t mode, logic halted);
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.mode_value  <= mode;
    in_ch.link_halted <= halted;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(advance_timers(kind, mode, halted));
    pace();
  endtask

  task automatic send_ticks(int n);
    repeat (n)
      send_item(KIND_TICK, mode_t'($urandom_range(0, 3)), $urandom_range(0, 7) == 0);
  endtask

  task automatic send_random_item();
    int r;
    kind_t kind;
    r = $urandom_range(0, 99);
    if (r < 70)      kind = KIND_TICK;
    else if (r < 75) kind = KIND_ARM_WATCH;
    else if (r < 85) kind = KIND_SET_MODE;
    else if (r < 91) kind = KIND_SEND_GO;
    else if (r < 97) kind = KIND_SEND_DONE;
    else             kind = KIND_SEND_DONE + kind_t'($urandom_range(1, 3));
    send_item(kind, mode_t'($urandom_range(0, 3)), $urandom_range(0, 7) == 0);
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_led_variant(logic four);
    wait_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= four;
    @(posedge clk);
    cfg_we   <= 1'b0;
    four_led  = four;
  endtask

  task automatic test_directed();
    send_item(KIND_SEND_GO, MODE_BLINK, 1'b0);
    send_item(KIND_TICK, MODE_BLINK, 1'b1);
    send_item(KIND_TICK, MODE_CLEAR, 1'b1);
    send_item(KIND_SEND_DONE, MODE_IDLE, 1'b0);
    send_item(KIND_TICK, MODE_FLASH, 1'b0);
    send_item(KIND_TICK, MODE_FLASH, 1'b0);
    send_item(KIND_SET_MODE, MODE_FLASH, 1'b1);
    send_ticks(2);
    send_item(KIND_SET_MODE, MODE_CLEAR, 1'b0);
    send_ticks(2);
    send_item(KIND_SET_MODE, MODE_IDLE, 1'b0);
    send_ticks(2);
    send_item(KIND_SET_MODE, MODE_BLINK, 1'b0);
    send_item(KIND_ARM_WATCH, MODE_IDLE, 1'b0);
    // arming again while already armed
    send_item(KIND_ARM_WATCH, MODE_FLASH, 1'b1);
    // unused kinds
    for (int i = 1; i <= 3; i++)
      send_item(KIND_SEND_DONE + kind_t'(i), MODE_FLASH, 1'b1);
    send_ticks(1);
  endtask

  task automatic test_random(int n);
    repeat (n) send_random_item();
  endtask

  task automatic test_backpressure();
    hold_req = ~hold_req;
    repeat (60) send_random_item();
    wait_results();
  endtask

  task automatic test_four_led();
    send_item(KIND_ARM_WATCH, MODE_BLINK, 1'b0);
    send_item(KIND_SET_MODE, MODE_BLINK, 1'b0);
    send_ticks(510);
    // flash entered with a phase past its end
    send_item(KIND_SET_MODE, MODE_FLASH, 1'b0);
    send_ticks(20);
    send_item(KIND_SET_MODE, MODE_CLEAR, 1'b0);
    send_ticks(4);
    send_item(KIND_SET_MODE, MODE_IDLE, 1'b0);
    send_ticks(4);
    send_item(KIND_SET_MODE, MODE_FLASH, 1'b0);
    send_ticks(410);
  endtask

  task automatic test_send_timer();
    send_item(KIND_SEND_GO, MODE_BLINK, 1'b0);
    send_ticks(60);
    send_item(KIND_SEND_DONE, MODE_BLINK, 1'b0);
    send_ticks(20);
    send_item(KIND_SEND_GO, MODE_BLINK, 1'b1);
    send_ticks(20);
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_TICK;
    in_ch.mode_value  <= MODE_BLINK;
    in_ch.link_halted <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_led_variant(1'b0);
    test_directed();
    test_random(240);
    test_backpressure();
    write_led_variant(1'b1);
    test_four_led();
    test_random(240);
    write_led_variant(1'b0);
    test_send_timer();

    wait_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ttlb_pkg.sv
rtl/ttlb_in_if.sv
rtl/ttlb_out_if.sv
rtl/tick_timers_with_led_blinker.sv
dv/testbench.sv
